[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the RTL, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[rtl/core/tws_pkg.sv]
// ----------------------------------------------------------------------------
// tws_pkg
// Constants, byte classes and the command, status and result types shared by
// the word statistics controller, datapath and top level.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int MAX_WORD_CHARS = 32;
    localparam int IDX_W          = $clog2(MAX_WORD_CHARS);
    localparam int CNT_W          = $clog2(MAX_WORD_CHARS + 1);
    localparam int ADDR_W         = IDX_W + 1;
    localparam int MEM_DEPTH      = 2 ** ADDR_W;

    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_EXCL   = 8'h21;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic accept;
        logic close;
        logic fetch;
        logic step;
        logic clear;
    } tws_cmd_t;

    typedef struct packed {
        logic done;
    } tws_status_t;

    typedef struct packed {
        logic [31:0] word_total;
        logic [31:0] letter_total;
        logic [7:0]  longest_length;
        logic [7:0]  longest_char;
        logic        char_valid;
        logic        last_result;
    } tws_result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'd48) && (b <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return ((b >= 8'd33) && (b <= 8'd47)) || ((b >= 8'd58) && (b <= 8'd64)) ||
               ((b >= 8'd91) && (b <= 8'd96)) || ((b >= 8'd123) && (b <= 8'd126));
    endfunction

    function automatic logic is_stop(input logic [7:0] b);
        return (b == CH_PERIOD) || (b == CH_EXCL) || (b == CH_QUERY) || (b == CH_COMMA);
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

[rtl/core/text_word_statistics.sv]
// ----------------------------------------------------------------------------
// text_word_statistics
// Word count, letter total and longest word over a text byte stream.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle while s_axis_tready is high, which
// it is whenever no word is being closed and no readout is running. After
// the byte marked by tlast the block closes the open word and then sends
// one result per stored character of the longest word (a single result if
// no word was kept). Each result is a read of the word memory and then the
// transfer, which m_axis_tready can hold back; s_axis_tready stays low
// until the final result has been taken. The word memory has two banks of
// MAX_WORD_CHARS bytes. The average word length is letter_total / word_total.
// ----------------------------------------------------------------------------
module text_word_statistics
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // word_total, letter_total, longest_length,
                                        // longest_char
    output logic        m_axis_tuser,   // char_valid
    output logic        m_axis_tlast    // last_result
);
    import tws_pkg::*;
    `include "assert_macros.svh"

    tws_cmd_t    cmd;
    tws_status_t status;
    tws_result_t result;

    tws_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    tws_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_code (s_axis_tdata),
        .status    (status),
        .result    (result)
    );

    assign m_axis_tdata = {result.longest_char, result.longest_length,
                           result.letter_total, result.word_total};
    assign m_axis_tuser = result.char_valid;
    assign m_axis_tlast = result.last_result;

    `ASSERT_PROP(a_empty_single, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast, "Empty result is not the only result.")
    `ASSERT_PROP(a_valid_matches_len, m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[71:64] != 8'd0)), "Character flag disagrees with the longest length.")

endmodule

[rtl/core/tws_ctrl.sv]
// ----------------------------------------------------------------------------
// tws_ctrl
// Controller of the word statistics block: takes text bytes, closes the run
// after the last byte and sequences the readout of the longest word.
// ----------------------------------------------------------------------------
module tws_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tws_pkg::tws_cmd_t    cmd,
    input  tws_pkg::tws_status_t status
);
    import tws_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_SEND  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.done)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_PROP(a_close_after_last, (in_valid && in_ready && in_last) |=> (state_reg == ST_CLOSE), "Last byte was not followed by the closing cycle.")
    `ASSERT_NEVER(a_no_take_in_readout, in_ready && out_valid, "Input taken during readout.")

endmodule

[rtl/core/tws_datapath.sv]
// ----------------------------------------------------------------------------
// tws_datapath
// Word state, statistics counters and the two-bank word memory. One bank
// collects the current word while the other holds the longest word so far;
// a new longest word swaps the banks.
// ----------------------------------------------------------------------------
module tws_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tws_pkg::tws_cmd_t    cmd,
    input  logic [7:0]           char_code,
    output tws_pkg::tws_status_t status,
    output tws_pkg::tws_result_t result
);
    import tws_pkg::*;
    `include "assert_macros.svh"

    logic             digit_reg, digit_next;
    logic             open_reg, open_next;
    logic             held_reg, held_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       best_reg, best_next;
    logic [31:0]      words_reg, words_next;
    logic [31:0]      letters_reg, letters_next;
    logic             bank_reg, bank_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [MEM_DEPTH];

    logic             b_space, b_digit, b_alpha, b_punct, b_stop;
    logic             held_app, end_now, close_word, keep;
    logic [7:0]       len_held;
    logic [32:0]      letters_sum;
    logic             wr_en;
    logic [7:0]       wr_pos;
    logic [CNT_W-1:0] n_chars;
    logic             last_char;

    assign b_space  = is_space(char_code);
    assign b_digit  = is_digit(char_code);
    assign b_alpha  = is_alpha(char_code);
    assign b_punct  = is_punct(char_code);
    assign b_stop   = is_stop(char_code);

    assign held_app    = held_reg && !(b_space || b_punct);
    assign len_held    = held_app ? sat_inc8(len_reg) : len_reg;
    assign end_now     = b_space || (b_punct && (held_reg || b_stop || !open_reg));
    assign close_word  = cmd.close || (cmd.accept && end_now);
    assign keep        = open_reg && !digit_reg;
    assign letters_sum = {1'b0, letters_reg} + {25'd0, len_reg};

    always_comb
    begin
        digit_next   = digit_reg;
        open_next    = open_reg;
        held_next    = held_reg;
        len_next     = len_reg;
        best_next    = best_reg;
        words_next   = words_reg;
        letters_next = letters_reg;
        bank_next    = bank_reg;
        wr_en        = 1'b0;
        wr_pos       = len_reg;
        if (cmd.clear)
        begin
            digit_next   = 1'b0;
            open_next    = 1'b0;
            held_next    = 1'b0;
            len_next     = 8'd0;
            best_next    = 8'd0;
            words_next   = 32'd0;
            letters_next = 32'd0;
        end
        else if (close_word)
        begin
            if (keep)
            begin
                if (words_reg != 32'hFFFF_FFFF)
                begin
                    words_next = words_reg + 32'd1;
                end
                letters_next = letters_sum[32] ? 32'hFFFF_FFFF : letters_sum[31:0];
                if (len_reg > best_reg)
                begin
                    best_next = len_reg;
                    bank_next = ~bank_reg;
                end
            end
            digit_next = 1'b0;
            open_next  = 1'b0;
            held_next  = 1'b0;
            len_next   = 8'd0;
        end
        else if (cmd.accept)
        begin
            held_next = 1'b0;
            len_next  = len_held;
            if (b_digit)
            begin
                digit_next = 1'b1;
            end
            else if (b_alpha)
            begin
                open_next = 1'b1;
                wr_pos    = len_held;
                wr_en     = len_held < 8'(MAX_WORD_CHARS);
                len_next  = sat_inc8(len_held);
            end
            else if (b_punct)
            begin
                held_next = 1'b1;
                wr_en     = len_reg < 8'(MAX_WORD_CHARS);
            end
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.clear)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.step)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg   <= 1'b0;
            open_reg    <= 1'b0;
            held_reg    <= 1'b0;
            len_reg     <= 8'd0;
            best_reg    <= 8'd0;
            words_reg   <= 32'd0;
            letters_reg <= 32'd0;
            bank_reg    <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            digit_reg   <= digit_next;
            open_reg    <= open_next;
            held_reg    <= held_next;
            len_reg     <= len_next;
            best_reg    <= best_next;
            words_reg   <= words_next;
            letters_reg <= letters_next;
            bank_reg    <= bank_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{bank_reg, wr_pos[IDX_W-1:0]}] <= char_code;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[{~bank_reg, rd_idx_reg}];
        end
    end

    assign n_chars   = (best_reg < 8'(MAX_WORD_CHARS)) ? best_reg[CNT_W-1:0]
                                                        : CNT_W'(MAX_WORD_CHARS);
    assign last_char = (n_chars == '0) ||
                       ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == n_chars);

    assign status.done           = last_char;
    assign result.word_total     = words_reg;
    assign result.letter_total   = letters_reg;
    assign result.longest_length = best_reg;
    assign result.char_valid     = (n_chars != '0);
    assign result.longest_char   = (n_chars != '0) ? rd_data_reg : 8'd0;
    assign result.last_result    = last_char;

    `ASSERT_PROP(a_held_in_word, held_reg |-> open_reg, "Punctuation held outside an open word.")
    `ASSERT_PROP(a_len_idle_zero, !open_reg |-> (len_reg == 8'd0), "Word length not zero between words.")

endmodule
